// ----- rtl/core/rgbhsv_pkg.sv -----
package rgbhsv_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned HueW  = 9;
  localparam int unsigned PctW  = 7;
  localparam int unsigned HNumW = 17;
  localparam int unsigned SNumW = 15;

  localparam logic [17:0] DEG_PER_SECTOR = 18'd60;
  localparam logic [17:0] OFS_GREEN      = 18'd120;
  localparam logic [17:0] OFS_BLUE       = 18'd240;
  localparam logic [17:0] FULL_TURN      = 18'd360;
  localparam logic [14:0] PERCENT        = 15'd100;

  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  typedef struct packed {
    logic [HNumW-1:0] rem;
    logic             q;
  } hstep_t;

  typedef struct packed {
    logic [SNumW-1:0] rem;
    logic             q;
  } sstep_t;

  // one restoring-division step for the hue quotient
  function automatic hstep_t hue_step(logic [HNumW-1:0] rem, logic [ChanW-1:0] den,
                                      logic [3:0] sh);
    logic [HNumW-1:0] dsh;
    hstep_t           r;
    dsh   = {{(HNumW-ChanW){1'b0}}, den} << sh;
    r.q   = (rem >= dsh);
    r.rem = r.q ? rem - dsh : rem;
    return r;
  endfunction

  // one restoring-division step for the saturation quotient
  function automatic sstep_t sat_step(logic [SNumW-1:0] rem, logic [ChanW-1:0] den,
                                      logic [2:0] sh);
    logic [SNumW-1:0] dsh;
    sstep_t           r;
    dsh   = {{(SNumW-ChanW){1'b0}}, den} << sh;
    r.q   = (rem >= dsh);
    r.rem = r.q ? rem - dsh : rem;
    return r;
  endfunction

endpackage

// ----- rtl/core/rgb_to_hsv_converter.sv -----
// RGB to HSV pixel converter.
// Input channel: in_valid_i / in_ready_o with red_i, green_i, blue_i (8-bit each).
// Output channel: out_valid_o / out_ready_i with hue_o (degrees, 0..359),
// saturation_o and brightness_o (percent, 0..100), all truncated.
// Grey pixels give hue 0; black gives saturation 0.
// Throughput: one pixel per clock while the output is not stalled. The pipeline is five register stages:
// max/min and sector select, numerators, then two long divisions resolved
// up to three quotient bits per stage over three stages; the last stage is the
// output register.
// When the receiver stalls with a beat on the output, the whole pipeline
// holds and in_ready_o drops in the same cycle; nothing is lost or repeated.
// Empty stages do not hold the pipeline, so in_ready_o stays high while the
// output register is empty or being taken.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data in
// flight is dropped.
module rgb_to_hsv_converter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [rgbhsv_pkg::ChanW-1:0] red_i,
  input  logic [rgbhsv_pkg::ChanW-1:0] green_i,
  input  logic [rgbhsv_pkg::ChanW-1:0] blue_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rgbhsv_pkg::HueW-1:0]  hue_o,
  output logic [rgbhsv_pkg::PctW-1:0]  saturation_o,
  output logic [rgbhsv_pkg::PctW-1:0]  brightness_o
);
  import rgbhsv_pkg::*;

  logic adv;

  // stage 1
  logic              v1_q;
  logic [ChanW-1:0]  mx1_d, mx1_q, mn1_d, mn1_q;
  logic [1:0]        sec1_d, sec1_q;
  logic signed [8:0] diff1_d, diff1_q;

  // stage 2
  logic              v2_q;
  logic [ChanW-1:0]  den2_d, den2_q, mx2_q;
  logic [HNumW-1:0]  hrem2_d, hrem2_q;
  logic [SNumW-1:0]  srem2_d, srem2_q;
  logic [PctW-1:0]   val2_d, val2_q;
  logic signed [17:0] hnum;
  logic [SNumW-1:0]  vprod;
  logic [15:0]       vsum;

  // stage 3
  logic              v3_q;
  logic [ChanW-1:0]  den3_q, mx3_q;
  logic [HNumW-1:0]  hrem3_d, hrem3_q;
  logic [SNumW-1:0]  srem3_d, srem3_q;
  logic [2:0]        hq3_d, hq3_q, sq3_d, sq3_q;
  logic [PctW-1:0]   val3_q;

  // stage 4
  logic              v4_q;
  logic [ChanW-1:0]  den4_q, mx4_q;
  logic [HNumW-1:0]  hrem4_d, hrem4_q;
  logic [SNumW-1:0]  srem4_d, srem4_q;
  logic [5:0]        hq4_d, hq4_q, sq4_d, sq4_q;
  logic [PctW-1:0]   val4_q;

  // stage 5 (output)
  logic              v5_q;
  logic [HueW-1:0]   hue_d, hue_q;
  logic [PctW-1:0]   sat_d, sat_q, val5_q;

  hstep_t hs3, hs4, hs5;
  sstep_t ss3, ss4, ss5;
  logic [HNumW-1:0] hr3, hr4, hr5;
  logic [SNumW-1:0] sr3, sr4;

  assign adv        = !v5_q || out_ready_i;
  assign in_ready_o = adv;

  // stage 1: max, min, sector, signed difference
  always_comb begin
    mx1_d = red_i;
    mn1_d = red_i;
    if (green_i > mx1_d) mx1_d = green_i;
    if (blue_i > mx1_d)  mx1_d = blue_i;
    if (green_i < mn1_d) mn1_d = green_i;
    if (blue_i < mn1_d)  mn1_d = blue_i;
    if (red_i >= green_i && red_i >= blue_i) begin
      sec1_d  = SEC_RED;
      diff1_d = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= blue_i) begin
      sec1_d  = SEC_GREEN;
      diff1_d = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sec1_d  = SEC_BLUE;
      diff1_d = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  // stage 2: delta, numerators and brightness
  always_comb begin
    den2_d = mx1_q - mn1_q;
    hnum   = $signed({{9{diff1_q[8]}}, diff1_q}) * $signed(DEG_PER_SECTOR);
    case (sec1_q)
      SEC_GREEN: hnum = hnum + $signed(OFS_GREEN * {10'd0, den2_d});
      SEC_BLUE:  hnum = hnum + $signed(OFS_BLUE * {10'd0, den2_d});
      default: begin
        if (diff1_q < 0) hnum = hnum + $signed(FULL_TURN * {10'd0, den2_d});
      end
    endcase
    hrem2_d = hnum[HNumW-1:0];
    srem2_d = PERCENT * {{(SNumW-ChanW){1'b0}}, den2_d};
    vprod   = PERCENT * {{(SNumW-ChanW){1'b0}}, mx1_q};
    // floor(p / 255) = (p + 1 + (p >> 8)) >> 8
    vsum    = {1'b0, vprod} + 16'd1 + {9'd0, vprod[14:8]};
    val2_d  = vsum[14:8];
  end

  // stage 3: quotient bits hue 8..6, saturation 6..4
  always_comb begin
    hr3 = hrem2_q;
    sr3 = srem2_q;
    for (int i = 0; i < 3; i++) begin
      hs3 = hue_step(hr3, den2_q, 4'(8 - i));
      hq3_d[2-i] = hs3.q;
      hr3 = hs3.rem;
      ss3 = sat_step(sr3, mx2_q, 3'(6 - i));
      sq3_d[2-i] = ss3.q;
      sr3 = ss3.rem;
    end
    hrem3_d = hr3;
    srem3_d = sr3;
  end

  // stage 4: hue 5..3, saturation 3..1
  always_comb begin
    hr4 = hrem3_q;
    sr4 = srem3_q;
    hq4_d = {hq3_q, 3'd0};
    sq4_d = {sq3_q, 3'd0};
    for (int i = 0; i < 3; i++) begin
      hs4 = hue_step(hr4, den3_q, 4'(5 - i));
      hq4_d[2-i] = hs4.q;
      hr4 = hs4.rem;
      ss4 = sat_step(sr4, mx3_q, 3'(3 - i));
      sq4_d[2-i] = ss4.q;
      sr4 = ss4.rem;
    end
    hrem4_d = hr4;
    srem4_d = sr4;
  end

  // stage 5: hue 2..0, saturation 0, zero guards
  always_comb begin
    hr5 = hrem4_q;
    hue_d = {hq4_q, 3'd0};
    for (int i = 0; i < 3; i++) begin
      hs5 = hue_step(hr5, den4_q, 4'(2 - i));
      hue_d[2-i] = hs5.q;
      hr5 = hs5.rem;
    end
    ss5   = sat_step(srem4_q, mx4_q, 3'd0);
    sat_d = {sq4_q, ss5.q};
    if (den4_q == '0) hue_d = '0;
    if (mx4_q == '0)  sat_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx1_q   <= mx1_d;
      mn1_q   <= mn1_d;
      sec1_q  <= sec1_d;
      diff1_q <= diff1_d;

      den2_q  <= den2_d;
      mx2_q   <= mx1_q;
      hrem2_q <= hrem2_d;
      srem2_q <= srem2_d;
      val2_q  <= val2_d;

      den3_q  <= den2_q;
      mx3_q   <= mx2_q;
      hrem3_q <= hrem3_d;
      srem3_q <= srem3_d;
      hq3_q   <= hq3_d;
      sq3_q   <= sq3_d;
      val3_q  <= val2_q;

      den4_q  <= den3_q;
      mx4_q   <= mx3_q;
      hrem4_q <= hrem4_d;
      srem4_q <= srem4_d;
      hq4_q   <= hq4_d;
      sq4_q   <= sq4_d;
      val4_q  <= val3_q;

      hue_q   <= hue_d;
      sat_q   <= sat_d;
      val5_q  <= val4_q;
    end
  end

  assign out_valid_o  = v5_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = val5_q;

endmodule

// ----- rtl/core/rgbhsv_checker.sv -----
module rgbhsv_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [rgbhsv_pkg::ChanW-1:0] red_i,
  input logic [rgbhsv_pkg::ChanW-1:0] green_i,
  input logic [rgbhsv_pkg::ChanW-1:0] blue_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [rgbhsv_pkg::HueW-1:0]  hue_o,
  input logic [rgbhsv_pkg::PctW-1:0]  saturation_o,
  input logic [rgbhsv_pkg::PctW-1:0]  brightness_o
);
  import rgbhsv_pkg::*;

  // stalled input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(red_i)
      && $stable(green_i) && $stable(blue_i))
    else $error("input beat changed while stalled");

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hue_o)
      && $stable(saturation_o) && $stable(brightness_o))
    else $error("output beat changed while stalled");

  // input side only blocks on a stalled output beat
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without output stall");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hue_o < HueW'(360))
    else $error("hue out of range");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> saturation_o <= PctW'(100) && brightness_o <= PctW'(100))
    else $error("percent out of range");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_rgbhsv_checker (.*);

// ----- tb/rgb_to_hsv_converter_test.sv -----
`timescale 1ns / 1ps

module rgb_to_hsv_converter_test;
  import rgbhsv_pkg::*;

  localparam int SectorDeg   = 60;
  localparam int TurnDeg     = 360;
  localparam int Pct         = 100;
  localparam int ChanFull    = 255;
  localparam int QuietLimit  = 2000;
  localparam int HoldCycles  = 40;
  localparam int BurstPixels = 30;
  localparam int PhasePixels = 200;
  localparam int DrainCycles = 12;
  localparam int MaxPrinted  = 40;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] val;
  } hsv_t;

  typedef struct packed {
    pixel_t px;
    logic   fixed;
    hsv_t   want;
  } probe_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  localparam int NumProbes = 24;
  localparam probe_t Probes [NumProbes] = '{
    '{'{8'd0,   8'd0,   8'd0  }, 1'b1, '{9'd0,   7'd0,   7'd0  }},
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{9'd0,   7'd0,   7'd100}},
    '{'{8'd255, 8'd0,   8'd0  }, 1'b1, '{9'd0,   7'd100, 7'd100}},
    '{'{8'd0,   8'd255, 8'd0  }, 1'b1, '{9'd120, 7'd100, 7'd100}},
    '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{9'd240, 7'd100, 7'd100}},
    '{'{8'd255, 8'd255, 8'd0  }, 1'b1, '{9'd60,  7'd100, 7'd100}},
    '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{9'd180, 7'd100, 7'd100}},
    '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{9'd300, 7'd100, 7'd100}},
    '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{9'd0,   7'd0,   7'd50 }},
    '{'{8'd1,   8'd0,   8'd0  }, 1'b1, '{9'd0,   7'd100, 7'd0  }},
    '{'{8'd255, 8'd0,   8'd1  }, 1'b0, '0},
    '{'{8'd255, 8'd128, 8'd0  }, 1'b0, '0},
    '{'{8'd1,   8'd255, 8'd0  }, 1'b0, '0},
    '{'{8'd0,   8'd255, 8'd1  }, 1'b0, '0},
    '{'{8'd10,  8'd200, 8'd200}, 1'b0, '0},
    '{'{8'd200, 8'd10,  8'd200}, 1'b0, '0},
    '{'{8'd3,   8'd1,   8'd2  }, 1'b0, '0},
    '{'{8'd170, 8'd85,  8'd0  }, 1'b0, '0},
    '{'{8'd254, 8'd255, 8'd253}, 1'b0, '0},
    '{'{8'd1,   8'd1,   8'd0  }, 1'b0, '0},
    '{'{8'd0,   8'd1,   8'd1  }, 1'b0, '0},
    '{'{8'd1,   8'd0,   8'd1  }, 1'b0, '0},
    '{'{8'd254, 8'd1,   8'd127}, 1'b0, '0},
    '{'{8'd85,  8'd170, 8'd255}, 1'b0, '0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ChanW-1:0] red_i;
  logic [ChanW-1:0] green_i;
  logic [ChanW-1:0] blue_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [HueW-1:0]  hue_o;
  logic [PctW-1:0]  saturation_o;
  logic [PctW-1:0]  brightness_o;

  hsv_t hsv_pending[$];
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_left;
  int   pixels_sent;
  int   results_seen;
  int   mismatches;
  int   in_stalls;

  rgb_to_hsv_converter uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .red_i,
    .green_i,
    .blue_i,
    .out_valid_o,
    .out_ready_i,
    .hue_o,
    .saturation_o,
    .brightness_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic hsv_t predict_hsv(pixel_t px);
    int   r, g, b, top, bottom, span, num, h;
    hsv_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    top = r;
    bottom = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    span = top - bottom;
    res = '0;
    if (span != 0) begin
      if (top == r) begin
        num = SectorDeg * (g - b);
        if (num < 0) num += TurnDeg * span;
      end else if (top == g) begin
        num = SectorDeg * (b - r) + 2 * SectorDeg * span;
      end else begin
        num = SectorDeg * (r - g) + 4 * SectorDeg * span;
      end
      h = num / span;
      if (h >= TurnDeg) h -= TurnDeg;
      res.hue = HueW'(h);
    end
    if (top != 0) res.sat = PctW'(Pct * span / top);
    res.val = PctW'(Pct * top / ChanFull);
    return res;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    logic [ChanW-1:0] a, c;
    px = '{ChanW'($urandom), ChanW'($urandom), ChanW'($urandom)};
    a = ChanW'($urandom);
    c = ChanW'($urandom);
    case ($urandom_range(0, 9))
      6: px = '{a, a, a};
      7: begin
        case ($urandom_range(0, 2))
          0: px = '{a, a, c};
          1: px = '{a, c, a};
          default: px = '{c, a, a};
        endcase
      end
      8: px = '{ChanW'($urandom_range(0, 7)), ChanW'($urandom_range(0, 7)),
                ChanW'($urandom_range(0, 7))};
      9: begin
        case ($urandom_range(0, 2))
          0: px.red = $urandom_range(0, 1) ? '1 : '0;
          1: px.green = $urandom_range(0, 1) ? '1 : '0;
          default: px.blue = $urandom_range(0, 1) ? '1 : '0;
        endcase
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_SEND: begin
        send_idle_pct = 59;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        recv_stall_pct = 59;
      end
      IDLE_BOTH: begin
        send_idle_pct = 30;
        recv_stall_pct = 30;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  task automatic send_pixel(pixel_t px, logic fixed, hsv_t want);
    int gap;
    gap = 0;
    while (gap < 50 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i <= px.red;
    green_i <= px.green;
    blue_i <= px.blue;
    do begin
      @(posedge clk_i);
      if (!in_ready_o) in_stalls++;
    end while (!in_ready_o);
    hsv_pending.push_back(fixed ? want : predict_hsv(px));
    pixels_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (hsv_pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    if (mismatches < MaxPrinted)
      $display("mismatch on result %0d: %s got %0d, expected %0d",
               results_seen, field, got, want);
    mismatches++;
  endtask

  // receiver: random stalls, plus one long hold-off for the back-pressure burst
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hsv_pending.size() == 0) begin
        report_mismatch("unexpected beat, hue", int'(hue_o), 0);
      end else begin
        hsv_t want;
        want = hsv_pending.pop_front();
        if (hue_o !== want.hue) report_mismatch("hue", int'(hue_o), int'(want.hue));
        if (saturation_o !== want.sat)
          report_mismatch("saturation", int'(saturation_o), int'(want.sat));
        if (brightness_o !== want.val)
          report_mismatch("brightness", int'(brightness_o), int'(want.val));
      end
      results_seen++;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    red_i = '0;
    green_i = '0;
    blue_i = '0;
    out_ready_i = 1'b0;
    hold_left = 0;
    pixels_sent = 0;
    results_seen = 0;
    mismatches = 0;
    in_stalls = 0;
    set_idle(IDLE_NONE);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Probes[i]) send_pixel(Probes[i].px, Probes[i].fixed, Probes[i].want);
    wait_drained();

    for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
      set_idle(idle_mode_e'(m));
      repeat (PhasePixels) send_pixel(random_pixel(), 1'b0, '0);
      if (m == IDLE_RECV) begin
        // back-pressure burst: fill the pipe against a held output
        wait_drained();
        set_idle(IDLE_NONE);
        hold_left = HoldCycles;
        repeat (BurstPixels) send_pixel(random_pixel(), 1'b0, '0);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d pixels sent (%0d directed), %0d results checked, %0d input stalls seen,",
             pixels_sent, NumProbes, results_seen, in_stalls);
    $display("across four idling modes and a %0d-cycle output hold-off; %0d mismatches",
             HoldCycles, mismatches);
    if (mismatches == 0 && hsv_pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- rgb_to_hsv_converter.f -----
rtl/core/rgbhsv_pkg.sv
rtl/core/rgb_to_hsv_converter.sv
rtl/core/rgbhsv_checker.sv
tb/rgb_to_hsv_converter_test.sv
